// ===== sv/rba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types and constants of the range bitmap allocator: codes, default
// sizes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int IDX_W         = 16;
  localparam int OP_W          = 2;
  localparam int STAT_W        = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int RBA_WORDS     = 64;
  localparam int RBA_WORD_BITS = 64;

  typedef enum logic [OP_W-1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FIND  = 2'd3
  } rba_op_e;

  typedef enum logic [STAT_W-1:0] {
    RBA_OK    = 2'd0,
    RBA_RANGE = 2'd1,
    RBA_FULL  = 2'd2
  } rba_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INDEX = 1'd0,
    CFG_MAX_INDEX = 1'd1
  } rba_cfg_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RANGE,
    RES_OK,
    RES_GET,
    RES_FOUND,
    RES_FULL
  } rba_res_sel_e;

  typedef struct packed {
    logic         capture;
    logic         clr_step;
    logic         mul;
    logic         split;
    logic         ram_re;
    logic         scan_init;
    logic         scan_next;
    logic         wr_word;
    rba_res_sel_e res_sel;
    logic         out_load;
  } rba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_ok;
    logic is_find;
    logic in_range;
    logic is_get;
    logic scan_hit;
    logic scan_in_span;
    logic scan_end;
    logic out_free;
  } rba_stat_t;

endpackage

// ===== sv/rba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_req_if
// Request channel: operation and block number with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rba_req_if
  import rba_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] bit_index;

  modport source (output valid, output op, output bit_index, input ready);
  modport sink   (input valid, input op, input bit_index, output ready);
endinterface

// ===== sv/rba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_rsp_if
// Result channel: status, bit read and block found, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rba_rsp_if
  import rba_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              bit_value;
  logic [IDX_W-1:0]  found_index;

  modport source (output valid, output status, output bit_value, output found_index,
                  input ready);
  modport sink   (input valid, input status, input bit_value, input found_index,
                  output ready);
endinterface

// ===== sv/rba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rba_ram
  import rba_pkg::*;
#(
  parameter int  WIDTH = RBA_WORD_BITS,
  parameter int  DEPTH = RBA_WORDS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_ctrl
// Sequencer: clearing pass, request intake, read-modify-write, word scan
// for find and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module rba_ctrl
  import rba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  rba_stat_t stat_i,
  output rba_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_MUL     = 9'b000000100,
    S_SPLIT   = 9'b000001000,
    S_READ    = 9'b000010000,
    S_MODIFY  = 9'b000100000,
    S_SCAN_RD = 9'b001000000,
    S_SCAN_EV = 9'b010000000,
    S_DONE    = 9'b100000000
  } rba_state_e;

  rba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.res_sel = RES_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (!stat_i.range_ok) begin
          cmd_o.res_sel = RES_RANGE;
          state_d       = S_DONE;
        end else if (stat_i.is_find) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN_RD;
        end else if (!stat_i.in_range) begin
          cmd_o.res_sel = RES_RANGE;
          state_d       = S_DONE;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        cmd_o.ram_re = 1'b1;
        state_d      = S_MODIFY;
      end
      S_MODIFY: begin
        if (stat_i.is_get) begin
          cmd_o.res_sel = RES_GET;
        end else begin
          cmd_o.wr_word = 1'b1;
          cmd_o.res_sel = RES_OK;
        end
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        cmd_o.ram_re = 1'b1;
        state_d      = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (stat_i.scan_hit) begin
          cmd_o.res_sel = stat_i.scan_in_span ? RES_FOUND : RES_FULL;
          state_d       = S_DONE;
        end else if (stat_i.scan_end) begin
          cmd_o.res_sel = RES_FULL;
          state_d       = S_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/rba_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_dpath
// Datapath: range registers, request capture, offset split into word and
// bit by reciprocal multiply, bitmap RAM, free-bit search and result
// registers.
// ----------------------------------------------------------------------------
module rba_dpath
  import rba_pkg::*;
#(
  parameter int WORDS     = RBA_WORDS,
  parameter int WORD_BITS = RBA_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [IDX_W-1:0]     cfg_wdata_i,
  input  logic [OP_W-1:0]      req_op_i,
  input  logic [IDX_W-1:0]     req_bit_index_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output logic [STAT_W-1:0]    rsp_status_o,
  output logic                 rsp_bit_value_o,
  output logic [IDX_W-1:0]     rsp_found_index_o,
  input  rba_cmd_t             cmd_i,
  output rba_stat_t            stat_o
);

  localparam int          AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int          BW          = $clog2(WORD_BITS);
  localparam int          SPAN_W      = IDX_W + 1;
  localparam int unsigned CAP         = WORDS * WORD_BITS;
  localparam int          RECIP_SHIFT = IDX_W + BW;
  localparam longint      RECIP       = ((64'd1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int          RECIP_W     = IDX_W + 2;
  localparam int          PROD_W      = IDX_W + RECIP_W;

  logic [IDX_W-1:0]     min_q, max_q;
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [PROD_W-1:0]    prod_q;
  logic [AW-1:0]        addr_q;
  logic [BW-1:0]        bit_q;
  logic [SPAN_W-1:0]    base_q;
  logic [STAT_W-1:0]    res_status_q;
  logic                 res_bit_q;
  logic [IDX_W-1:0]     res_found_q;
  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic                 out_bit_q;
  logic [IDX_W-1:0]     out_found_q;

  logic [SPAN_W-1:0]    span;
  logic [IDX_W-1:0]     offset;
  logic [PROD_W-1:0]    prod_d;
  logic [IDX_W-1:0]     quot;
  logic [IDX_W-1:0]     rem;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wmask;
  logic [WORD_BITS-1:0] wdata;
  logic                 ram_we;
  logic [BW-1:0]        zero_pos;
  logic [SPAN_W-1:0]    scan_off;
  logic [SPAN_W-1:0]    next_base;

  // range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= IDX_W'(0);
      max_q <= IDX_W'(4095);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_INDEX: min_q <= cfg_wdata_i;
        CFG_MAX_INDEX: max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign span   = SPAN_W'({1'b0, max_q} - {1'b0, min_q} + SPAN_W'(1));
  assign offset = idx_q - min_q;
  assign prod_d = PROD_W'(offset) * PROD_W'(RECIP);
  assign quot   = IDX_W'(prod_q >> RECIP_SHIFT);
  assign rem    = offset - IDX_W'(quot * WORD_BITS);

  assign stat_o.range_ok = (min_q <= max_q) && (span <= SPAN_W'(CAP));
  assign stat_o.in_range = (idx_q >= min_q) && (idx_q <= max_q);
  assign stat_o.is_find  = (op_q == OP_FIND);
  assign stat_o.is_get   = (op_q == OP_GET);
  assign stat_o.clr_last = (addr_q == AW'(WORDS - 1));
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  // request and split registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_op_i;
      idx_q <= req_bit_index_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.split) begin
      bit_q <= rem[BW-1:0];
    end
    if (cmd_i.scan_init) begin
      base_q <= '0;
    end else if (cmd_i.scan_next) begin
      base_q <= next_base;
    end
  end

  // word address, doubles as clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.split) begin
      addr_q <= quot[AW-1:0];
    end else if (cmd_i.scan_init) begin
      addr_q <= '0;
    end else if (cmd_i.clr_step || cmd_i.scan_next) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  assign wmask  = WORD_BITS'(1) << bit_q;
  assign wdata  = cmd_i.clr_step ? '0 :
                  (op_q == OP_SET) ? (rdata | wmask) : (rdata & ~wmask);
  assign ram_we = cmd_i.clr_step || cmd_i.wr_word;

  rba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // lowest zero bit of the word just read
  always_comb begin
    zero_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata[i]) begin
        zero_pos = BW'(i);
      end
    end
  end

  assign scan_off            = base_q + SPAN_W'(zero_pos);
  assign next_base           = base_q + SPAN_W'(WORD_BITS);
  assign stat_o.scan_hit     = ~&rdata;
  assign stat_o.scan_in_span = (scan_off < span);
  assign stat_o.scan_end     = (next_base >= span);

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      RES_NONE: ;
      RES_RANGE: begin
        res_status_q <= RBA_RANGE;
        res_bit_q    <= 1'b0;
        res_found_q  <= '0;
      end
      RES_OK: begin
        res_status_q <= RBA_OK;
        res_bit_q    <= 1'b0;
        res_found_q  <= '0;
      end
      RES_GET: begin
        res_status_q <= RBA_OK;
        res_bit_q    <= rdata[bit_q];
        res_found_q  <= '0;
      end
      RES_FOUND: begin
        res_status_q <= RBA_OK;
        res_bit_q    <= 1'b0;
        res_found_q  <= min_q + scan_off[IDX_W-1:0];
      end
      RES_FULL: begin
        res_status_q <= RBA_FULL;
        res_bit_q    <= 1'b0;
        res_found_q  <= '0;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_bit_q    <= res_bit_q;
      out_found_q  <= res_found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_status_q;
  assign rsp_bit_value_o   = out_bit_q;
  assign rsp_found_index_o = out_found_q;

endmodule

// ===== sv/range_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_bitmap_allocator_unit
// Used/free bitmap over block numbers min_index..max_index with get, set,
// clear and find-lowest-free requests.
//
//   channel   direction  handshake        contents
//   req       in         valid/ready      op, bit_index
//   rsp       out        valid/ready      status, bit_value, found_index
//   cfg       in         cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// get, set and clear: capture, multiply, split, RAM read and modify, then the
// result. out-of-range or bad range: result straight after the multiply step.
// find: reads and checks bitmap words in turn until a free bit or the range end.
// after reset a clearing pass writes every RAM word, no requests.
// one request in flight; the next is taken while its result waits in rsp.
// ----------------------------------------------------------------------------
module range_bitmap_allocator_unit
  import rba_pkg::*;
#(
  parameter int WORDS     = RBA_WORDS,
  parameter int WORD_BITS = RBA_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rba_req_if.sink              req,
  rba_rsp_if.source            rsp,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [IDX_W-1:0]     cfg_wdata_i
);

  rba_cmd_t  cmd;
  rba_stat_t stat;

  rba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rba_dpath #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_op_i          (req.op),
    .req_bit_index_i   (req.bit_index),
    .rsp_valid_o       (rsp.valid),
    .rsp_ready_i       (rsp.ready),
    .rsp_status_o      (rsp.status),
    .rsp_bit_value_o   (rsp.bit_value),
    .rsp_found_index_o (rsp.found_index),
    .cmd_i             (cmd),
    .stat_o            (stat)
  );

endmodule

// ===== sv/rba_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_chk
// Port-level checks of the allocator: result hold, request/result
// balance and clean fields on error results.
// ----------------------------------------------------------------------------
module rba_chk
  import rba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [STAT_W-1:0] rsp_status_i,
  input logic              rsp_bit_value_i,
  input logic [IDX_W-1:0]  rsp_found_index_i
);

  logic [1:0] pending_q, pending_d;
  logic       req_acc, rsp_acc;

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_acc   = rsp_valid_i && rsp_ready_i;
  assign pending_d = pending_q + 2'(req_acc) - 2'(rsp_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before taken");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 2'd0)
    else $error("result without request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> pending_q <= 2'd1)
    else $error("too many requests in flight");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != RBA_OK |-> !rsp_bit_value_i && rsp_found_index_i == '0)
    else $error("error result carries data");

endmodule

bind range_bitmap_allocator_unit rba_chk u_rba_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_status_i      (rsp.status),
  .rsp_bit_value_i   (rsp.bit_value),
  .rsp_found_index_i (rsp.found_index)
);

// ===== verif/range_bitmap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_bitmap_allocator_unit_tb
// Self-checking bench for the range bitmap allocator. The bench keeps its own
// copy of the used/free map and the index limits and predicts the answer to
// each request: get, set, clear and find-lowest-free. A short table of
// directed requests covers the field extremes and the invalid and full
// cases, with some answers typed in. Then it moves to random traffic over
// several limit settings. Part of that traffic is find-then-claim
// allocation, which fills the small ranges. The request and result sides
// pause at random.
// ----------------------------------------------------------------------------
module range_bitmap_allocator_unit_tb;
  import rba_pkg::*;

  localparam int          CAPACITY     = RBA_WORDS * RBA_WORD_BITS;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 2 * RBA_WORDS + 4;
  localparam int          NUM_PHASES   = 8;
  localparam int          PLAN_LEN     = 35;

  typedef struct packed {
    rba_status_e      status;
    logic             bit_value;
    logic [IDX_W-1:0] found_index;
  } answer_t;

  typedef struct packed {
    logic             is_cfg;
    rba_cfg_e         sel;
    logic [IDX_W-1:0] value;
    rba_op_e          op;
    logic             typed;
    answer_t          answer;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [IDX_W-1:0]     cfg_wdata_i;

  rba_req_if req_ch ();
  rba_rsp_if rsp_ch ();

  range_bitmap_allocator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [RBA_WORD_BITS-1:0] used_map [RBA_WORDS];
  logic [IDX_W-1:0]         lim_min;
  logic [IDX_W-1:0]         lim_max;
  answer_t                  expected_answers [$];
  answer_t                  last_answer;
  int                       req_gap_pct;
  int                       rsp_stall_pct;
  int                       errors;
  int                       cycle_count;

  logic [IDX_W-1:0] phase_min [NUM_PHASES] = '{16'd0, 16'd1000, 16'd65528, 16'd0,
                                               16'd40000, 16'd61440, 16'd200, 16'd7};
  logic [IDX_W-1:0] phase_max [NUM_PHASES] = '{16'd4095, 16'd1031, 16'd65535, 16'd4096,
                                               16'd39999, 16'd65535, 16'd263, 16'd7};

  step_t plan [PLAN_LEN] = '{
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_GET,   1'b1, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd4095,  OP_GET,   1'b1, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd4096,  OP_GET,   1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'hFFFF,  OP_FIND,  1'b1, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_SET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_SET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd4095,  OP_SET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd65535, OP_GET,   1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_CLEAR, 1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_CLEAR, 1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b1, CFG_MAX_INDEX, 16'd65535, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd5,     OP_GET,   1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd5,     OP_SET,   1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b1, CFG_MIN_INDEX, 16'd100,   OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b1, CFG_MAX_INDEX, 16'd99,    OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b1, CFG_MIN_INDEX, 16'd0,     OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b1, CFG_MAX_INDEX, 16'd0,     OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_SET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b1, '{RBA_FULL,  1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd1,     OP_GET,   1'b1, '{RBA_RANGE, 1'b0, 16'd0}},
    '{1'b1, CFG_MIN_INDEX, 16'd65535, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b1, CFG_MAX_INDEX, 16'd65535, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd65535, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b1, '{RBA_FULL,  1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd65535, OP_CLEAR, 1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b1, '{RBA_OK,    1'b0, 16'd65535}},
    '{1'b1, CFG_MIN_INDEX, 16'd61440, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b1, CFG_MAX_INDEX, 16'd65535, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd61440, OP_GET,   1'b0, '{RBA_OK,    1'b0, 16'd0}},
    '{1'b0, CFG_MIN_INDEX, 16'd0,     OP_FIND,  1'b0, '{RBA_OK,    1'b0, 16'd0}}
  };

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic limits_ok();
    return (lim_min <= lim_max) && ((32'(lim_max) - 32'(lim_min) + 1) <= CAPACITY);
  endfunction

  function automatic answer_t predict_answer(rba_op_e op, logic [IDX_W-1:0] idx);
    answer_t     ans;
    int unsigned span;
    int unsigned pos;
    int unsigned off;
    logic        hit;
    ans = '{RBA_OK, 1'b0, '0};
    if (!limits_ok()) begin
      ans.status = RBA_RANGE;
    end else if (op == OP_FIND) begin
      span = 32'(lim_max) - 32'(lim_min) + 1;
      ans.status = RBA_FULL;
      hit = 1'b0;
      for (pos = 0; pos < span && !hit; pos++) begin
        if (!used_map[(pos / RBA_WORD_BITS) % RBA_WORDS][pos % RBA_WORD_BITS]) begin
          hit = 1'b1;
          ans.status = RBA_OK;
          ans.found_index = IDX_W'(32'(lim_min) + pos);
        end
      end
    end else if (idx < lim_min || idx > lim_max) begin
      ans.status = RBA_RANGE;
    end else begin
      off = 32'(idx) - 32'(lim_min);
      case (op)
        OP_GET: begin
          ans.bit_value = used_map[(off / RBA_WORD_BITS) % RBA_WORDS][off % RBA_WORD_BITS];
        end
        OP_SET: begin
          used_map[(off / RBA_WORD_BITS) % RBA_WORDS][off % RBA_WORD_BITS] = 1'b1;
        end
        default: begin
          used_map[(off / RBA_WORD_BITS) % RBA_WORDS][off % RBA_WORD_BITS] = 1'b0;
        end
      endcase
    end
    return ans;
  endfunction

  // called and returns at a falling edge
  task automatic send_request(rba_op_e op, logic [IDX_W-1:0] idx, logic typed,
                              answer_t typed_ans);
    answer_t ans;
    while ($urandom_range(99) < req_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.bit_index <= idx;
    do @(posedge clk_i); while (!req_ch.ready);
    ans = predict_answer(op, idx);
    last_answer = ans;
    expected_answers.push_back(typed ? typed_ans : ans);
    @(negedge clk_i);
  endtask

  task automatic settle_idle();
    req_ch.valid <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_limit(rba_cfg_e sel, logic [IDX_W-1:0] value);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_MIN_INDEX) begin
      lim_min = value;
    end else begin
      lim_max = value;
    end
  endtask

  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    answer_t exp;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result: status %0d bit_value %0d found_index %0d",
               rsp_ch.status, rsp_ch.bit_value, rsp_ch.found_index);
        errors++;
      end else begin
        exp = expected_answers.pop_front();
        if (rsp_ch.status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.bit_value !== exp.bit_value) begin
          $error("bit_value: expected %0d, actual %0d", exp.bit_value, rsp_ch.bit_value);
          errors++;
        end
        if (rsp_ch.found_index !== exp.found_index) begin
          $error("found_index: expected %0d, actual %0d", exp.found_index,
                 rsp_ch.found_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int               s;
    int               p;
    int               n;
    int               mode;
    int               pick;
    int unsigned      span;
    logic             range_valid;
    rba_op_e          op;
    logic [IDX_W-1:0] idx;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_MIN_INDEX;
    cfg_wdata_i      = '0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_GET;
    req_ch.bit_index = '0;
    rsp_ch.ready     = 1'b0;
    req_gap_pct      = 18;
    rsp_stall_pct    = 70;
    errors           = 0;
    cycle_count      = 0;
    lim_min          = 16'd0;
    lim_max          = 16'd4095;
    foreach (used_map[w]) used_map[w] = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (s = 0; s < PLAN_LEN; s++) begin
      if (plan[s].is_cfg) begin
        write_limit(plan[s].sel, plan[s].value);
      end else begin
        send_request(plan[s].op, plan[s].value, plan[s].typed, plan[s].answer);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      mode = p * 3 / NUM_PHASES;
      req_gap_pct   = (mode == 0) ? 18 : (mode == 1) ? 70 : 0;
      rsp_stall_pct = (mode == 0) ? 70 : (mode == 1) ? 18 : 0;
      write_limit(CFG_MIN_INDEX, phase_min[p]);
      write_limit(CFG_MAX_INDEX, phase_max[p]);
      range_valid = limits_ok();
      span = 32'(lim_max) - 32'(lim_min) + 1;
      for (n = 0; n < (range_valid ? 95 : 40); n++) begin
        pick = $urandom_range(99);
        if (!range_valid) begin
          send_request(rba_op_e'($urandom_range(3)), IDX_W'($urandom_range(65535)),
                       1'b0, '0);
        end else if (pick < 30) begin
          // allocate: find the lowest free block, then claim it
          send_request(OP_FIND, IDX_W'($urandom_range(65535)), 1'b0, '0);
          if (last_answer.status == RBA_OK) begin
            send_request(OP_SET, last_answer.found_index, 1'b0, '0);
          end
        end else begin
          pick = $urandom_range(99);
          op = (pick < 30) ? OP_GET : (pick < 60) ? OP_SET : (pick < 85) ? OP_CLEAR : OP_FIND;
          pick = $urandom_range(99);
          if (pick < 75) begin
            idx = IDX_W'(32'(lim_min) + $urandom_range(span - 1));
          end else if (pick < 85) begin
            case ($urandom_range(3))
              0:       idx = lim_min - 16'd1;
              1:       idx = lim_max + 16'd1;
              2:       idx = lim_min;
              default: idx = lim_max;
            endcase
          end else begin
            idx = IDX_W'($urandom_range(65535));
          end
          send_request(op, idx, 1'b0, '0);
        end
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
